@@ src/wsr_pkg.sv @@
package wsr_pkg;

    localparam logic [2:0] OP_BIND      = 3'd0;
    localparam logic [2:0] OP_CREATE    = 3'd1;
    localparam logic [2:0] OP_DESTROY   = 3'd2;
    localparam logic [2:0] OP_POLL_MSG  = 3'd3;
    localparam logic [2:0] OP_PUSH_EV   = 3'd4;
    localparam logic [2:0] OP_POLL_EV   = 3'd5;
    localparam logic [2:0] OP_TASK_EXIT = 3'd6;
    localparam logic [2:0] OP_RSVD      = 3'd7;

    localparam logic [1:0] PH_EMPTY           = 2'd0;
    localparam logic [1:0] PH_OPEN_PENDING    = 2'd1;
    localparam logic [1:0] PH_LIVE            = 2'd2;
    localparam logic [1:0] PH_DESTROY_PENDING = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;

    localparam logic [1:0] MSG_NONE   = 2'd0;
    localparam logic [1:0] MSG_OPENED = 2'd1;
    localparam logic [1:0] MSG_CLOSED = 2'd2;

    localparam int MAX_SIDE   = 1024;
    localparam int PAGE_BYTES = 4096;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] caller_pid;
        logic [31:0] wid;
        logic [10:0] width;
        logic [10:0] height;
        logic [31:0] event_word;
        logic        size_ok;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  msg_op;
        logic [31:0] wid;
        logic [15:0] owner;
        logic [10:0] width;
        logic [10:0] height;
        logic [3:0]  slot;
        logic [31:0] event_word;
    } t_result;

endpackage

@@ src/wsr_ram.sv @@
module wsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/wsr_front.sv @@
module wsr_front #(
    parameter int MAX_PAGES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [2:0]          i_operation,
    input  logic [15:0]         i_caller_pid,
    input  logic [31:0]         i_window_id,
    input  logic [15:0]         i_width,
    input  logic [15:0]         i_height,
    input  logic [31:0]         i_event_word,
    output logic                o_valid,
    input  logic                i_take,
    output wsr_pkg::t_request   o_req
);

    localparam logic [35:0] AreaLimit = 36'(MAX_PAGES * (wsr_pkg::PAGE_BYTES / 4));

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_AREA = 2'd1;
    localparam logic [1:0] F_PUT  = 2'd2;

    logic [1:0]        r_stage;
    logic [2:0]        r_op;
    logic [15:0]       r_pid;
    logic [31:0]       r_wid;
    logic [10:0]       r_w;
    logic [10:0]       r_h;
    logic [31:0]       r_ev;
    logic              r_side_ok;
    logic [21:0]       r_area;
    wsr_pkg::t_request r_q [2];
    logic [1:0]        r_qv;
    logic [1:0]        n_qv;
    logic              r_wp;
    logic              r_rp;
    logic              side_ok;
    logic              take;
    logic              put;

    assign side_ok = (i_width != 16'd0) && (i_height != 16'd0)
        && (i_width <= 16'(wsr_pkg::MAX_SIDE)) && (i_height <= 16'(wsr_pkg::MAX_SIDE));
    assign o_full  = (r_stage != F_IDLE);
    assign o_valid = r_qv[r_rp];
    assign o_req   = r_q[r_rp];
    assign take    = i_take && r_qv[r_rp];
    assign put     = (r_stage == F_PUT) && !r_qv[r_wp];

    always_comb begin
        n_qv = r_qv;
        if (take) begin
            n_qv[r_rp] = 1'b0;
        end
        if (put) begin
            n_qv[r_wp] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= F_IDLE;
            r_qv    <= 2'b00;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            r_qv <= n_qv;
            if (take) begin
                r_rp <= ~r_rp;
            end
            unique case (r_stage)
                F_IDLE: begin
                    if (i_push) begin
                        r_op      <= i_operation;
                        r_pid     <= i_caller_pid;
                        r_wid     <= i_window_id;
                        r_w       <= i_width[10:0];
                        r_h       <= i_height[10:0];
                        r_ev      <= i_event_word;
                        r_side_ok <= side_ok;
                        r_stage   <= F_AREA;
                    end
                end
                F_AREA: begin
                    r_area  <= r_w * r_h;
                    r_stage <= F_PUT;
                end
                default: begin
                    if (put) begin
                        r_q[r_wp] <= '{operation: r_op, caller_pid: r_pid, wid: r_wid,
                            width: r_w, height: r_h, event_word: r_ev,
                            size_ok: r_side_ok && ({14'd0, r_area} <= AreaLimit)};
                        r_wp    <= ~r_wp;
                        r_stage <= F_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

@@ src/wsr_back.sv @@
module wsr_back #(
    parameter int MAX_WINDOWS = 16,
    parameter int EVENT_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_take,
    input  wsr_pkg::t_request i_req,
    output logic              o_empty,
    input  logic              i_pop,
    output wsr_pkg::t_result  o_res
);

    localparam int SW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int EW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int CW = $clog2(EVENT_DEPTH + 1);
    localparam int NW = $clog2(MAX_WINDOWS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        r_state;
    wsr_pkg::t_request r_req;
    logic [NW-1:0]     r_idx;
    logic              r_found;
    logic [SW-1:0]     r_slot;
    logic              r_mgr_bound;
    logic [15:0]       r_mgr_pid;
    logic [31:0]       r_next_id;
    logic [1:0]        r_phase [MAX_WINDOWS];
    logic [31:0]       r_sid   [MAX_WINDOWS];
    logic [15:0]       r_owner [MAX_WINDOWS];
    logic [10:0]       r_sw    [MAX_WINDOWS];
    logic [10:0]       r_sh    [MAX_WINDOWS];
    logic [EW-1:0]     r_head  [MAX_WINDOWS];
    logic [EW-1:0]     r_tail  [MAX_WINDOWS];
    logic [CW-1:0]     r_count [MAX_WINDOWS];
    wsr_pkg::t_result  r_res;
    wsr_pkg::t_result  r_out;
    logic              r_full;

    logic [SW-1:0]     cur;
    logic [1:0]        ph;
    logic              is_mgr;
    logic              hit;
    logic              last;
    logic              own_ok;
    logic              slot_open;
    logic              create_ok;
    logic              to_read;
    logic              out_load;
    wsr_pkg::t_result  exec_res;
    logic              ram_we;
    logic [SW+EW-1:0]  ram_waddr;
    logic [SW+EW-1:0]  ram_raddr;
    logic [31:0]       ram_rdata;

    assign cur       = r_idx[SW-1:0];
    assign ph        = r_phase[cur];
    assign is_mgr    = r_mgr_bound && (r_mgr_pid == r_req.caller_pid);
    assign last      = (r_idx == NW'(MAX_WINDOWS - 1));
    assign o_take    = (r_state == S_IDLE) && i_valid;
    assign o_empty   = !r_full;
    assign o_res     = r_out;
    assign own_ok    = r_found && (r_owner[r_slot] == r_req.caller_pid);
    assign slot_open = (r_phase[r_slot] == wsr_pkg::PH_LIVE)
        || (r_phase[r_slot] == wsr_pkg::PH_OPEN_PENDING);
    assign create_ok = r_mgr_bound && r_req.size_ok && r_found;
    assign to_read   = (r_req.operation == wsr_pkg::OP_POLL_EV) && own_ok
        && (r_count[r_slot] != '0);
    assign out_load  = (r_state == S_OUT) && (!r_full || i_pop);

    always_comb begin
        hit = 1'b0;
        unique case (r_req.operation) inside
            wsr_pkg::OP_CREATE: hit = (ph == wsr_pkg::PH_EMPTY);
            wsr_pkg::OP_DESTROY, wsr_pkg::OP_PUSH_EV, wsr_pkg::OP_POLL_EV:
                hit = (ph != wsr_pkg::PH_EMPTY) && (r_sid[cur] == r_req.wid);
            wsr_pkg::OP_POLL_MSG:
                hit = (ph == wsr_pkg::PH_OPEN_PENDING) || (ph == wsr_pkg::PH_DESTROY_PENDING);
            default: hit = 1'b0;
        endcase
    end

    assign ram_we    = (r_state == S_EXEC) && (r_req.operation == wsr_pkg::OP_PUSH_EV)
        && r_found && is_mgr && slot_open;
    assign ram_waddr = {r_slot, r_tail[r_slot]};
    assign ram_raddr = {r_slot, r_head[r_slot]};

    wsr_ram #(.WIDTH(32), .DEPTH(MAX_WINDOWS * (2 ** EW))) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_req.event_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    function automatic logic [EW-1:0] inc(input logic [EW-1:0] v);
        logic [EW:0] t;
        t = {1'b0, v} + 1'b1;
        inc = (t == (EW+1)'(EVENT_DEPTH)) ? '0 : t[EW-1:0];
    endfunction

    always_comb begin
        exec_res = '{status: wsr_pkg::ST_REJECT, default: '0};
        unique case (r_req.operation)
            wsr_pkg::OP_BIND: begin
                if (!r_mgr_bound) begin
                    exec_res.status = wsr_pkg::ST_DONE;
                end
            end
            wsr_pkg::OP_CREATE: begin
                if (create_ok) begin
                    exec_res = '{status: wsr_pkg::ST_DONE, msg_op: wsr_pkg::MSG_NONE,
                        wid: r_next_id, owner: r_req.caller_pid,
                        width: r_req.width, height: r_req.height,
                        slot: 4'(r_slot), event_word: '0};
                end
            end
            wsr_pkg::OP_DESTROY: begin
                if (own_ok && slot_open) begin
                    exec_res.status = wsr_pkg::ST_DONE;
                end
            end
            wsr_pkg::OP_POLL_MSG: begin
                if (is_mgr) begin
                    if (!r_found) begin
                        exec_res.status = wsr_pkg::ST_NONE;
                    end else if (r_phase[r_slot] == wsr_pkg::PH_OPEN_PENDING) begin
                        exec_res = '{status: wsr_pkg::ST_DONE,
                            msg_op: wsr_pkg::MSG_OPENED,
                            wid: r_sid[r_slot], owner: r_owner[r_slot],
                            width: r_sw[r_slot], height: r_sh[r_slot],
                            slot: 4'(r_slot), event_word: '0};
                    end else begin
                        exec_res = '{status: wsr_pkg::ST_DONE,
                            msg_op: wsr_pkg::MSG_CLOSED,
                            wid: r_sid[r_slot], owner: r_owner[r_slot],
                            width: '0, height: '0,
                            slot: 4'(r_slot), event_word: '0};
                    end
                end
            end
            wsr_pkg::OP_PUSH_EV: begin
                if (ram_we) begin
                    exec_res.status = wsr_pkg::ST_DONE;
                end
            end
            wsr_pkg::OP_POLL_EV: begin
                if (own_ok && r_count[r_slot] == '0) begin
                    exec_res.status = wsr_pkg::ST_NONE;
                end
            end
            wsr_pkg::OP_TASK_EXIT: begin
                exec_res.status = wsr_pkg::ST_DONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_full      <= 1'b0;
            r_mgr_bound <= 1'b0;
            r_mgr_pid   <= '0;
            r_next_id   <= 32'd1;
            for (int k = 0; k < MAX_WINDOWS; k++) begin
                r_phase[k] <= wsr_pkg::PH_EMPTY;
                r_sid[k]   <= '0;
                r_owner[k] <= '0;
                r_sw[k]    <= '0;
                r_sh[k]    <= '0;
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_full <= out_load || (r_full && !i_pop);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_req;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_slot  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_req.operation == wsr_pkg::OP_BIND
                            || r_req.operation == wsr_pkg::OP_TASK_EXIT
                            || r_req.operation == wsr_pkg::OP_RSVD) begin
                        r_state <= S_EXEC;
                    end else if (hit) begin
                        r_found <= 1'b1;
                        r_slot  <= cur;
                        r_state <= S_EXEC;
                    end else if (last) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EXEC: begin
                    r_res   <= exec_res;
                    r_state <= to_read ? S_READ : S_OUT;
                    unique case (r_req.operation)
                        wsr_pkg::OP_BIND: begin
                            if (!r_mgr_bound) begin
                                r_mgr_bound <= 1'b1;
                                r_mgr_pid   <= r_req.caller_pid;
                                for (int k = 0; k < MAX_WINDOWS; k++) begin
                                    r_phase[k] <= wsr_pkg::PH_EMPTY;
                                    r_head[k]  <= '0;
                                    r_tail[k]  <= '0;
                                    r_count[k] <= '0;
                                end
                            end
                        end
                        wsr_pkg::OP_CREATE: begin
                            if (create_ok) begin
                                r_sid[r_slot]   <= r_next_id;
                                r_owner[r_slot] <= r_req.caller_pid;
                                r_sw[r_slot]    <= r_req.width;
                                r_sh[r_slot]    <= r_req.height;
                                r_head[r_slot]  <= '0;
                                r_tail[r_slot]  <= '0;
                                r_count[r_slot] <= '0;
                                r_phase[r_slot] <= wsr_pkg::PH_OPEN_PENDING;
                                r_next_id       <= r_next_id + 32'd1;
                            end
                        end
                        wsr_pkg::OP_DESTROY: begin
                            if (own_ok && slot_open) begin
                                r_phase[r_slot] <= wsr_pkg::PH_DESTROY_PENDING;
                            end
                        end
                        wsr_pkg::OP_POLL_MSG: begin
                            if (is_mgr && r_found) begin
                                if (r_phase[r_slot] == wsr_pkg::PH_OPEN_PENDING) begin
                                    r_phase[r_slot] <= wsr_pkg::PH_LIVE;
                                end else begin
                                    r_phase[r_slot] <= wsr_pkg::PH_EMPTY;
                                    r_head[r_slot]  <= '0;
                                    r_tail[r_slot]  <= '0;
                                    r_count[r_slot] <= '0;
                                end
                            end
                        end
                        wsr_pkg::OP_PUSH_EV: begin
                            if (ram_we) begin
                                r_tail[r_slot] <= inc(r_tail[r_slot]);
                                if (r_count[r_slot] == CW'(EVENT_DEPTH)) begin
                                    r_head[r_slot] <= inc(r_head[r_slot]);
                                end else begin
                                    r_count[r_slot] <= r_count[r_slot] + 1'b1;
                                end
                            end
                        end
                        wsr_pkg::OP_TASK_EXIT: begin
                            for (int k = 0; k < MAX_WINDOWS; k++) begin
                                if (is_mgr) begin
                                    if (r_phase[k] == wsr_pkg::PH_DESTROY_PENDING) begin
                                        r_phase[k] <= wsr_pkg::PH_EMPTY;
                                        r_head[k]  <= '0;
                                        r_tail[k]  <= '0;
                                        r_count[k] <= '0;
                                    end
                                end else if ((r_phase[k] == wsr_pkg::PH_LIVE
                                        || r_phase[k] == wsr_pkg::PH_OPEN_PENDING)
                                        && r_owner[k] == r_req.caller_pid) begin
                                    r_phase[k] <= wsr_pkg::PH_DESTROY_PENDING;
                                end
                            end
                            if (is_mgr) begin
                                r_mgr_bound <= 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_READ: begin
                    r_res <= '{status: wsr_pkg::ST_DONE, event_word: ram_rdata, default: '0};
                    r_head[r_slot]  <= inc(r_head[r_slot]);
                    r_count[r_slot] <= r_count[r_slot] - 1'b1;
                    r_state         <= S_OUT;
                end
                default: begin
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

@@ src/window_slot_registry.sv @@
// Window slot registry: one result per request, in request order. The back stage scans the
// slots one per cycle, up to MAX_WINDOWS, and stops at the first hit (bind, task exit and the
// unused code do not search); a poll event that finds a queued event then reads the ring RAM
// in a read state, and a result waits in the back stage until the previous one is popped. After
// each accepted request full stays high while the front stage checks the size and until the
// request enters the queue. A two-entry queue lets the back stage, busy with the scan, execute
// and any ring read of a request, work while the front stage takes the next request.
module window_slot_registry #(
    parameter int MAX_WINDOWS = 16,
    parameter int EVENT_DEPTH = 16,
    parameter int MAX_PAGES   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_caller_pid,
    input  logic [31:0] i_window_id,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    input  logic [31:0] i_event_word,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [1:0]  o_msg_op,
    output logic [31:0] o_out_window_id,
    output logic [15:0] o_out_owner_pid,
    output logic [10:0] o_out_width,
    output logic [10:0] o_out_height,
    output logic [3:0]  o_out_slot,
    output logic [31:0] o_out_event
);

    wsr_pkg::t_request req;
    wsr_pkg::t_result  res;
    logic              req_valid;
    logic              req_take;

    wsr_front #(.MAX_PAGES(MAX_PAGES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_operation  (i_operation),
        .i_caller_pid (i_caller_pid),
        .i_window_id  (i_window_id),
        .i_width      (i_width),
        .i_height     (i_height),
        .i_event_word (i_event_word),
        .o_valid      (req_valid),
        .i_take       (req_take),
        .o_req        (req)
    );

    wsr_back #(.MAX_WINDOWS(MAX_WINDOWS), .EVENT_DEPTH(EVENT_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_take  (req_take),
        .i_req   (req),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res)
    );

    assign o_status        = res.status;
    assign o_msg_op        = res.msg_op;
    assign o_out_window_id = res.wid;
    assign o_out_owner_pid = res.owner;
    assign o_out_width     = res.width;
    assign o_out_height    = res.height;
    assign o_out_slot      = res.slot;
    assign o_out_event     = res.event_word;

endmodule
